@@ src/imvm_pkg.sv @@
`default_nettype none

package imvm_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    localparam int ROW_FIELD_W = 4;
    localparam int COL_FIELD_W = 4;
    localparam int VALUE_W     = 64;
    localparam int CFG_W       = 5;

    // Request mode codes
    localparam logic MODE_MATRIX = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    // Register index codes (paddr[2])
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [ROW_FIELD_W-1:0]    row;
        logic [COL_FIELD_W-1:0]    col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_req_t;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0]    row_index;
        logic signed [VALUE_W-1:0] dot_product;
        logic                      final_res;
        logic                      in_null_space;
    } out_res_t;

    // Operands into the shared multiplier, tagged with their row
    typedef struct packed {
        logic                   valid;
        logic [ROW_FIELD_W-1:0] row;
        logic [VALUE_W-1:0]     a;
        logic [VALUE_W-1:0]     b;
    } mul_op_t;

    // Product out of the shared multiplier
    typedef struct packed {
        logic                   valid;
        logic [ROW_FIELD_W-1:0] row;
        logic [VALUE_W-1:0]     product;
    } mul_res_t;

    // Accumulator bank control: add into one row, or clear every row
    typedef struct packed {
        logic                   add_en;
        logic                   clr_all;
        logic [ROW_FIELD_W-1:0] row;
        logic [VALUE_W-1:0]     addend;
    } acc_ctl_t;

endpackage

`default_nettype wire

@@ src/imvm_mul.sv @@
`default_nettype none

module imvm_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire imvm_pkg::mul_op_t op,
    output imvm_pkg::mul_res_t     res,
    output logic                   busy
);
    import imvm_pkg::*;

    logic                   s1_valid_reg;
    logic [ROW_FIELD_W-1:0] s1_row_reg;
    logic [63:0]            pp_ll_reg;
    logic [31:0]            pp_lh_reg;
    logic [31:0]            pp_hl_reg;

    logic [63:0]            pp_ll_next;
    logic [31:0]            pp_lh_next;
    logic [31:0]            pp_hl_next;

    logic                   s2_valid_reg;
    logic [ROW_FIELD_W-1:0] s2_row_reg;
    logic [VALUE_W-1:0]     s2_prod_reg;
    logic [VALUE_W-1:0]     s2_prod_next;

    // Low 64 bits of the product only need the low-by-low term in full
    // and the low 32 bits of the two cross terms.
    always_comb begin
        pp_ll_next   = 64'(op.a[31:0]) * 64'(op.b[31:0]);
        pp_lh_next   = op.a[31:0] * op.b[63:32];
        pp_hl_next   = op.a[63:32] * op.b[31:0];
        s2_prod_next = pp_ll_reg + {pp_lh_reg + pp_hl_reg, 32'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= op.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_row_reg  <= op.row;
        pp_ll_reg   <= pp_ll_next;
        pp_lh_reg   <= pp_lh_next;
        pp_hl_reg   <= pp_hl_next;
        s2_row_reg  <= s1_row_reg;
        s2_prod_reg <= s2_prod_next;
    end

    assign res.valid   = s2_valid_reg;
    assign res.row     = s2_row_reg;
    assign res.product = s2_prod_reg;
    assign busy        = s1_valid_reg | s2_valid_reg;

endmodule

`default_nettype wire

@@ src/imvm_acc.sv @@
`default_nettype none

module imvm_acc #(
    parameter int ROWS = imvm_pkg::MAX_ROWS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire imvm_pkg::acc_ctl_t ctl,
    output logic [63:0]             rd_data
);
    import imvm_pkg::*;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [VALUE_W-1:0] acc_reg [ROWS];
    logic [ROW_W-1:0]   idx;

    assign idx     = ctl.row[ROW_W-1:0];
    assign rd_data = acc_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clr_all) begin
            for (int i = 0; i < ROWS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (ctl.add_en) begin
            acc_reg[idx] <= acc_reg[idx] + ctl.addend;
        end
    end

endmodule

`default_nettype wire

@@ src/int_matrix_vector_multiply_unit.sv @@
// Integer matrix-vector multiply unit.
//
// Load the matrix through the request channel (s_*) with mode = matrix, one
// entry per request. Then send the vector
// with mode = vector, one element per request, marking the final element
// with last. On the marked element the unit returns one result per row in
// use on the m_* channel, in row order; the final one carries final_res and
// in_null_space (set when every row sum was zero).
// Flow: s_ready stays low while an element is processed, so a new element
// is taken only once every product of the one before has landed. The
// single multiply-accumulate pipeline (one memory read port, one 64-bit
// multiplier cut into 32-bit partial products) handles one row per cycle.
// After the last element the unit emits one result per row in use.
// When the receiver stalls, the output register holds its result and
// emission pauses; a new request may be taken once the final result sits
// in the output register. rows_in_use and cols_in_use sit on the APB port
// at offsets 0x0 and 0x4; write them only while the unit is idle.
// Reset clears the accumulators and sets both registers to 16.
`default_nettype none

module int_matrix_vector_multiply_unit #(
    parameter int MAX_ROWS = imvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = imvm_pkg::MAX_COLS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire imvm_pkg::in_req_t s_data,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output imvm_pkg::out_res_t     m_data,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import imvm_pkg::*;

    // Only 16 rows and columns are reachable through the 4-bit fields.
    localparam int ROWS_EFF  = (MAX_ROWS < 16) ? MAX_ROWS : 16;
    localparam int COLS_EFF  = (MAX_COLS < 16) ? MAX_COLS : 16;
    localparam int MEM_DEPTH = ROWS_EFF * COLS_EFF;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] v,
                                                     logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_W'(16);
            cols_cfg_reg <= CFG_W'(16);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_COLS_IN_USE) begin
                cols_cfg_reg <= pwdata[CFG_W-1:0];
            end else begin
                rows_cfg_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLS_IN_USE) ? {27'b0, cols_cfg_reg}
                                                  : {27'b0, rows_cfg_reg};

    logic [CFG_W-1:0] nrows;
    logic [CFG_W-1:0] ncols;

    assign nrows = clamp_count(rows_cfg_reg, CFG_W'(ROWS_EFF));
    assign ncols = clamp_count(cols_cfg_reg, CFG_W'(COLS_EFF));

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   cnt_reg, cnt_next;
    logic [MEM_AW-1:0]  rd_addr_reg, rd_addr_next;
    logic [VALUE_W-1:0] vec_reg, vec_next;
    logic               last_reg, last_next;
    logic               any_nz_reg, any_nz_next;
    logic               rd_valid_reg;
    logic [3:0]         rd_row_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               m_valid_reg, m_valid_next;
    out_res_t           m_data_reg, m_data_next;

    logic               s_fire;
    logic               mat_wr;
    logic               issue;
    logic               emit_load;
    logic               emit_fin;
    logic [MEM_AW-1:0]  wr_addr;

    mul_op_t            mul_op;
    mul_res_t           mul_res;
    logic               mul_busy;
    acc_ctl_t           acc_ctl;
    logic [VALUE_W-1:0] acc_rd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign mat_wr    = s_fire && (s_data.mode == MODE_MATRIX)
                       && (32'(s_data.row) < ROWS_EFF) && (32'(s_data.col) < COLS_EFF);
    assign wr_addr   = MEM_AW'(32'(s_data.row) * COLS_EFF + 32'(s_data.col));
    assign issue     = (state_reg == ST_ISSUE);
    assign emit_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_fin  = (cnt_reg == nrows - CFG_W'(1));

    // ---------------------------------------------------------------
    // Matrix store: one write port, one registered read port
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (mat_wr) begin
            mem[wr_addr] <= s_data.value;
        end
        rd_data_reg <= mem[rd_addr_reg];
        rd_row_reg  <= cnt_reg[3:0];
    end

    // ---------------------------------------------------------------
    // Shared multiply and accumulator bank
    // ---------------------------------------------------------------
    assign mul_op.valid = rd_valid_reg;
    assign mul_op.row   = rd_row_reg;
    assign mul_op.a     = rd_data_reg;
    assign mul_op.b     = vec_reg;

    imvm_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mul_op),
        .res     (mul_res),
        .busy    (mul_busy)
    );

    // One accumulator port: products land during accumulation, the emit
    // counter reads it during emission; the two phases never overlap.
    assign acc_ctl.add_en  = mul_res.valid;
    assign acc_ctl.clr_all = emit_load && emit_fin;
    assign acc_ctl.row     = mul_res.valid ? mul_res.row : cnt_reg[3:0];
    assign acc_ctl.addend  = mul_res.product;

    imvm_acc #(
        .ROWS (ROWS_EFF)
    ) u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .rd_data (acc_rd)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_addr_next = rd_addr_reg;
        vec_next     = vec_reg;
        last_next    = last_reg;
        any_nz_next  = any_nz_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.mode == MODE_VECTOR)) begin
                    vec_next     = s_data.value;
                    last_next    = s_data.last;
                    cnt_next     = '0;
                    rd_addr_next = MEM_AW'(s_data.col);
                    // an element beyond the vector length adds nothing
                    if (CFG_W'(s_data.col) < ncols) begin
                        state_next = ST_ISSUE;
                    end else begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_ISSUE: begin
                // advance one row per cycle down the column
                rd_addr_next = rd_addr_reg + MEM_AW'(COLS_EFF);
                cnt_next     = cnt_reg + CFG_W'(1);
                if (emit_fin) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // hold until every product has landed in its accumulator
                if (!rd_valid_reg && !mul_busy) begin
                    cnt_next = '0;
                    if (last_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_valid_next              = 1'b1;
                    m_data_next.row_index     = cnt_reg[3:0];
                    m_data_next.dot_product   = acc_rd;
                    m_data_next.final_res     = emit_fin;
                    m_data_next.in_null_space = emit_fin && !any_nz_reg && (acc_rd == '0);
                    any_nz_next               = any_nz_reg || (acc_rd != '0);
                    cnt_next                  = cnt_reg + CFG_W'(1);
                    if (emit_fin) begin
                        any_nz_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            any_nz_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            any_nz_reg   <= any_nz_next;
            rd_valid_reg <= issue;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        vec_reg     <= vec_next;
        last_reg    <= last_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_read_in_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("matrix read outstanding outside accumulation");

    a_no_add_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !mul_res.valid)
        else $error("product landed while emitting results");

    a_final_on_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) ##1 (state_reg == ST_IDLE)
        |-> m_valid_reg && m_data_reg.final_res)
        else $error("emission ended without a final result");

    a_null_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.in_null_space) |-> m_data_reg.final_res)
        else $error("null-space flag on a non-final result");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
    import imvm_pkg::*;

    // Settle time after the last expected sum, covering an element still in flight.
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 500;
    localparam int RANDOM_ITEMS  = 240;
    localparam int CYCLE_LIMIT   = 1000000;

    // Keeps its own copy of the matrix, the row accumulators and both size
    // registers; every accepted request updates the copy and queues the
    // row sums that the unit must return.
    class row_sum_board;
        logic [63:0] matrix_copy [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];
        logic [63:0] acc_copy [0:MAX_ROWS_DEF-1];
        logic [4:0]  rows_reg;
        logic [4:0]  cols_reg;
        out_res_t    due_sums [$];
        int          err_count;

        function new();
            foreach (matrix_copy[i]) matrix_copy[i] = '0;
            foreach (acc_copy[i]) acc_copy[i] = '0;
            rows_reg  = 5'd16;
            cols_reg  = 5'd16;
            err_count = 0;
        endfunction

        function int unsigned fit_count(logic [4:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned eff_rows();
            return fit_count(rows_reg, MAX_ROWS_DEF);
        endfunction

        function int unsigned eff_cols();
            return fit_count(cols_reg, MAX_COLS_DEF);
        endfunction

        function int pending();
            return due_sums.size();
        endfunction

        function void set_reg(logic idx, logic [31:0] v);
            if (idx == REG_ROWS_IN_USE)
                rows_reg = v[4:0];
            else
                cols_reg = v[4:0];
        endfunction

        function void note_request(in_req_t req);
            int unsigned nr;
            int unsigned nc;
            bit          all_zero;
            out_res_t    res;
            if (req.mode == MODE_MATRIX) begin
                matrix_copy[int'(req.row) * MAX_COLS_DEF + int'(req.col)] = req.value;
                return;
            end
            nr = eff_rows();
            nc = eff_cols();
            if (req.col < nc) begin
                for (int r = 0; r < nr; r++)
                    acc_copy[r] += matrix_copy[r * MAX_COLS_DEF + int'(req.col)] * req.value;
            end
            if (!req.last) return;
            all_zero = 1'b1;
            for (int r = 0; r < nr; r++) begin
                if (acc_copy[r] != 0) all_zero = 1'b0;
                res.row_index     = 4'(r);
                res.dot_product   = acc_copy[r];
                res.final_res     = (r == nr - 1);
                res.in_null_space = (r == nr - 1) && all_zero;
                due_sums = {due_sums, res};
            end
            foreach (acc_copy[i]) acc_copy[i] = '0;
        endfunction

        task report_mismatch(string msg);
            err_count++;
            if (err_count <= 40) $display("mismatch: %s", msg);
        endtask

        task check_sum(out_res_t got);
            out_res_t want;
            if (due_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected sum for row %0d", got.row_index));
                return;
            end
            want = due_sums.pop_front();
            if (got.row_index !== want.row_index)
                report_mismatch($sformatf("row_index got %0d want %0d",
                                          got.row_index, want.row_index));
            if (got.dot_product !== want.dot_product)
                report_mismatch($sformatf("row %0d dot_product got %h want %h",
                                          want.row_index, got.dot_product, want.dot_product));
            if (got.final_res !== want.final_res)
                report_mismatch($sformatf("row %0d final_res got %b want %b",
                                          want.row_index, got.final_res, want.final_res));
            if (got.in_null_space !== want.in_null_space)
                report_mismatch($sformatf("row %0d in_null_space got %b want %b",
                                          want.row_index, got.in_null_space,
                                          want.in_null_space));
        endtask
    endclass

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Every input starts from a known value
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_req_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_res_t    m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    row_sum_board sb = new();

    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          no_gaps = 1'b0;

    int_matrix_vector_multiply_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mix extremes, powers of two, small signed values and full random words
    // so that every bit of the value field toggles.
    function automatic logic [63:0] rand_value();
        int unsigned pick;
        logic [63:0] near_zero;
        pick      = $urandom_range(0, 15);
        near_zero = 64'($urandom_range(0, 32)) - 64'd16;
        case (pick)
            0:       return '0;
            1:       return 64'd1;
            2:       return '1;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return 64'h8000_0000_0000_0000;
            5:       return 64'd1 << $urandom_range(0, 63);
            6, 7, 8: return near_zero;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Size register values: mostly small, with zero and out-of-range values,
    // and junk in the upper bits half of the time.
    function automatic logic [31:0] rand_cfg();
        logic [4:0]  v;
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p < 4)
            v = 5'($urandom_range(1, 4));
        else if (p < 7)
            v = 5'($urandom_range(5, 16));
        else if (p == 7)
            v = 5'd0;
        else
            v = 5'($urandom_range(17, 31));
        if ($urandom_range(0, 1) == 1) return {27'($urandom), v};
        return {27'd0, v};
    endfunction

    // Idle gap before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int unsigned p;
        if (no_gaps) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_req_t make_req(logic mode, logic [3:0] row, logic [3:0] col,
                                         logic [63:0] value, logic last);
        in_req_t req;
        req.mode  = mode;
        req.row   = row;
        req.col   = col;
        req.value = value;
        req.last  = last;
        return req;
    endfunction

    // Offer one request after a random gap and hold it until accepted.
    // Entered at a clock edge; keep valid high when there is no gap so it is
    // never dropped and raised in the same step.
    task automatic send_req(in_req_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        items_sent++;
    endtask

    function automatic in_req_t rand_matrix_req();
        return make_req(MODE_MATRIX, 4'($urandom), 4'($urandom), rand_value(),
                        1'($urandom));
    endfunction

    // Send len vector elements. In-order vectors walk the columns from a
    // random start; wild ones pick any column, so indices repeat, go missing
    // or fall out of range.
    task automatic send_vector(int unsigned len, int unsigned offset, bit wild,
                               bit zero_vals, bit mid_writes, bit mark_last);
        logic [3:0] col;
        for (int i = 0; i < len; i++) begin
            if (wild)
                col = 4'($urandom_range(0, 15));
            else
                col = 4'((i + offset) % len);
            if (mid_writes && $urandom_range(0, 3) == 0)
                send_req(rand_matrix_req());
            send_req(make_req(MODE_VECTOR, 4'($urandom), col,
                              zero_vals ? 64'd0 : rand_value(),
                              mark_last && (i == len - 1)));
        end
    endtask

    // Write one size register through APB, only once the unit is idle:
    // drop valid, drain every due sum, let any element in flight finish.
    task automatic write_reg(logic idx, logic [31:0] val);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: check every accepted sum, stall at random, and twice hold
    // off for a long stretch so the unit backs up into its request channel.
    int unsigned sums_taken = 0;
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;
    int unsigned stall_pick;

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sb.check_sum(m_data);
            sums_taken++;
        end
        if (hold_left == 0 && holds_done < 2 &&
            sums_taken >= (holds_done == 0 ? 100 : 400)) begin
            hold_left = LONG_HOLD;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 9) < 4) begin
            run_left = $urandom_range(0, 30);
            m_ready <= 1'b1;
        end else begin
            stall_pick = $urandom_range(0, 9);
            stall_left = (stall_pick < 7) ? $urandom_range(0, 2) :
                         (stall_pick < 9) ? $urandom_range(3, 9) : $urandom_range(20, 80);
            m_ready <= 1'b0;
        end
    end

    // Watchdog: end the run if it overruns the generous limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[int_matrix_vector_multiply_unit] ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int unsigned p;
        int unsigned k;
        int unsigned len;
        int unsigned random_start;

        // Hold reset, then release it once
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Load every matrix entry first so no vector element reads an
        // entry that was never written.
        for (int r = 0; r < MAX_ROWS_DEF; r++) begin
            for (int c = 0; c < MAX_COLS_DEF; c++)
                send_req(make_req(MODE_MATRIX, 4'(r), 4'(c), rand_value(), 1'($urandom)));
        end

        // Directed: full-range elements at the reset sizes
        send_req(make_req(MODE_VECTOR, 4'hF, 4'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd15, 64'h8000_0000_0000_0000, 1'b1));
        // zero vector: every sum zero, null-space flag set
        send_req(make_req(MODE_VECTOR, 4'h3, 4'd3, 64'd0, 1'b1));
        // last flag on a matrix write is ignored
        send_req(make_req(MODE_MATRIX, 4'd15, 4'd15, '1, 1'b1));
        // out-of-range element index that still carries last
        write_reg(REG_COLS_IN_USE, 32'd4);
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd9, '1, 1'b1));
        // repeated index accumulates twice
        send_req(make_req(MODE_VECTOR, 4'h1, 4'd1, 64'd5, 1'b0));
        send_req(make_req(MODE_VECTOR, 4'h1, 4'd1, 64'd5, 1'b0));
        send_req(make_req(MODE_VECTOR, 4'h2, 4'd2, '1, 1'b1));
        // matrix write in the middle of a vector counts for later elements
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd0, 64'd3, 1'b0));
        send_req(make_req(MODE_MATRIX, 4'd0, 4'd1, 64'd1 << 32, 1'b0));
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd1, 64'd1 << 32, 1'b1));
        // nonzero operands whose product wraps to zero: null space on one row
        write_reg(REG_ROWS_IN_USE, 32'd1);
        send_req(make_req(MODE_MATRIX, 4'd0, 4'd0, 64'd1 << 32, 1'b0));
        send_req(make_req(MODE_VECTOR, 4'h7, 4'd0, 64'd1 << 32, 1'b1));
        // zero sizes act as one
        write_reg(REG_ROWS_IN_USE, 32'd0);
        write_reg(REG_COLS_IN_USE, 32'd0);
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd0, 64'd7, 1'b1));
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd1, 64'd7, 1'b1));
        // oversized values act as the maximum
        write_reg(REG_ROWS_IN_USE, 32'd31);
        write_reg(REG_COLS_IN_USE, 32'd17);
        send_req(make_req(MODE_VECTOR, 4'h0, 4'd15, '1, 1'b1));
        // upper data bits are dropped: both land on 16
        write_reg(REG_ROWS_IN_USE, 32'hFFFF_FFF0);
        write_reg(REG_COLS_IN_USE, 32'hFFFF_FFF0);

        // Random: mostly well-formed vectors with random content, some
        // broken ones, matrix rewrites and size changes between them.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            p       = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (p < 8) begin
                write_reg(REG_ROWS_IN_USE, rand_cfg());
                if ($urandom_range(0, 1) == 1) write_reg(REG_COLS_IN_USE, rand_cfg());
            end else if (p < 22) begin
                repeat ($urandom_range(1, 4)) send_req(rand_matrix_req());
            end else if (p < 27) begin
                // change a size halfway through a vector
                k = $urandom_range(1, 8);
                send_vector(k, 0, 1'b0, 1'b0, 1'b0, 1'b0);
                write_reg($urandom_range(0, 1) ? REG_ROWS_IN_USE : REG_COLS_IN_USE,
                          rand_cfg());
                len = sb.eff_cols();
                send_vector(len, $urandom_range(0, 15), 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
                len = (p < 45) ? $urandom_range(1, 20) : sb.eff_cols();
                send_vector(len, $urandom_range(0, 15), p < 45,
                            $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0, 1'b1);
            end
        end

        // Drain: drop valid, wait for every due sum, then settle
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.err_count == 0) begin
            $display("[int_matrix_vector_multiply_unit] OK");
        end else begin
            $display("[int_matrix_vector_multiply_unit] ERROR");
        end
        $finish;
    end
endmodule
